// ----- sv/tplca_pkg.sv -----
// Shared types and constants for the tree path prime count LCA core.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package tplca_pkg;
   localparam int NODE_W        = 16;
   localparam int CNT_W         = 16;
   localparam int SIEVE_SIZE    = 65536;
   localparam int SIEVE_ROOT    = 256;
   localparam int DEF_MAX_NODES = 65536;
   localparam int DEF_LEVELS    = 16;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef struct packed {
      logic en;
      logic we;
   } mem_cmd_type;
endpackage

// ----- sv/tree_path_prime_count_lca_core.sv -----
// Top level: binary-lifting tree store with path prime count queries.
// Depends on tplca_pkg, tplca_ram and tplca_sieve.
//
//   channel | dir | tdata                          | tuser
//   req_    | in  | node_a [15:0], node_b [31:16]  | op [0]
//   rsp_    | out | ancestor [15:0], prime_count [31:16] | -
//
// A load does one node read, one node write and one level-0 ancestor write,
// then one ancestor read and write per higher level on the single table port.
// A query runs a dependent read chain on the ancestor table port: one lift per
// set bit of the depth gap, then, unless the nodes meet, two reads per level.
// After reset the sieve sweep runs first; no word is taken until it is done.
// A finished result waits in the output register while the next word is taken.
`timescale 1ns / 1ps
module tree_path_prime_count_lca_core #(
   parameter int MAX_NODES = tplca_pkg::DEF_MAX_NODES,
   parameter int LEVELS    = tplca_pkg::DEF_LEVELS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // node_a [15:0], node_b [31:16]
   input  logic [0:0]  req_tuser,   // op [0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // ancestor [15:0], prime_count [31:16]
);
   import tplca_pkg::*;

   localparam int AW  = $clog2(MAX_NODES);
   localparam int LW  = $clog2(LEVELS);
   localparam int TAW = LW + AW;

   typedef enum logic [4:0] {
      S_IDLE, L_RD, L_WR, L_A0, L_AR, L_AW,
      Q_RA, Q_RB, Q_SW, Q_LR, Q_LC, Q_EQ, Q_JA, Q_JB, Q_JC,
      Q_ZR, Q_ZC, Q_PR, Q_PC, Q_CZ, Q_CP, Q_OUT
   } state_type;

   function automatic logic [NODE_W-1:0] map_node(input logic [NODE_W-1:0] v);
      map_node = ({16'b0, v} < 32'(MAX_NODES)) ? v : '0;
   endfunction

   state_type         state_ff, state_in;
   logic [NODE_W-1:0] a_ff, a_in, b_ff, b_in, r_ff, r_in;
   logic [LW-1:0]     k_ff, k_in;
   logic [LEVELS-1:0] diff_ff, diff_in;
   logic [15:0]       da_ff, da_in;
   logic [CNT_W-1:0]  sum_ff, sum_in, ca_ff, ca_in;
   logic              zf_ff, zf_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [31:0]       rsp_data_ff, rsp_data_in;

   mem_cmd_type       tcmd, ncmd;
   logic [TAW-1:0]    taddr;
   logic [NODE_W-1:0] twdata, trdata_raw, tdat;
   logic [AW-1:0]     naddr;
   logic [31:0]       nwdata, nrdata_raw, ndat;
   logic [NODE_W-1:0] rd_node;
   logic              prime_flag, sieve_ready;
   logic [15:0]       dgap;

   tplca_ram #(.WIDTH(NODE_W), .ADDR_W(TAW)) u_anc (
      .clock(clock), .cmd(tcmd), .addr(taddr), .wdata(twdata), .rdata(trdata_raw)
   );

   tplca_ram #(.WIDTH(32), .ADDR_W(AW)) u_node (
      .clock(clock), .cmd(ncmd), .addr(naddr), .wdata(nwdata), .rdata(nrdata_raw)
   );

   tplca_sieve u_sieve (
      .clock(clock), .reset(reset), .rd_addr(a_ff), .rd_flag(prime_flag),
      .ready(sieve_ready)
   );

   // node 0 reads as zero in both stores
   assign tdat = zf_ff ? '0 : trdata_raw;
   assign ndat = zf_ff ? '0 : nrdata_raw;
   assign dgap = ndat[31:16] - da_ff;

   assign req_tready = (state_ff == S_IDLE) && sieve_ready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      a_in         = a_ff;
      b_in         = b_ff;
      r_in         = r_ff;
      k_in         = k_ff;
      diff_in      = diff_ff;
      da_in        = da_ff;
      ca_in        = ca_ff;
      sum_in       = sum_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      tcmd         = '0;
      ncmd         = '0;
      rd_node      = a_ff;
      taddr        = {k_ff, AW'(a_ff)};
      twdata       = b_ff;
      naddr        = AW'(a_ff);
      nwdata       = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               a_in = map_node(req_tdata[15:0]);
               b_in = map_node(req_tdata[31:16]);
               if (req_tuser[0] == OP_QUERY) begin
                  state_in = Q_RA;
               end else if (map_node(req_tdata[15:0]) != '0) begin
                  state_in = L_RD;
               end
            end
         end
         L_RD: begin
            ncmd     = '{en: 1'b1, we: 1'b0};
            naddr    = AW'(b_ff);
            rd_node  = b_ff;
            state_in = L_WR;
         end
         L_WR: begin
            ncmd     = '{en: 1'b1, we: 1'b1};
            nwdata   = {ndat[31:16] + 16'd1, ndat[15:0] + 16'(prime_flag)};
            state_in = L_A0;
         end
         L_A0: begin
            tcmd     = '{en: 1'b1, we: 1'b1};
            taddr    = {LW'(0), AW'(a_ff)};
            twdata   = b_ff;
            k_in     = LW'(1);
            state_in = L_AR;
         end
         L_AR: begin
            tcmd     = '{en: 1'b1, we: 1'b0};
            taddr    = {LW'(k_ff - LW'(1)), AW'(b_ff)};
            rd_node  = b_ff;
            state_in = L_AW;
         end
         L_AW: begin
            tcmd   = '{en: 1'b1, we: 1'b1};
            taddr  = {k_ff, AW'(a_ff)};
            twdata = tdat;
            b_in   = tdat;
            if (k_ff == LW'(LEVELS - 1)) begin
               state_in = S_IDLE;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = L_AR;
            end
         end
         Q_RA: begin
            ncmd     = '{en: 1'b1, we: 1'b0};
            state_in = Q_RB;
         end
         Q_RB: begin
            da_in    = ndat[31:16];
            ca_in    = ndat[15:0];
            ncmd     = '{en: 1'b1, we: 1'b0};
            naddr    = AW'(b_ff);
            rd_node  = b_ff;
            state_in = Q_SW;
         end
         Q_SW: begin
            sum_in = ca_ff + ndat[15:0];
            k_in   = '0;
            if (da_ff < ndat[31:16]) begin
               a_in    = b_ff;
               b_in    = a_ff;
               diff_in = LEVELS'(dgap);
            end else begin
               diff_in = LEVELS'(16'(-dgap));
            end
            state_in = Q_LR;
         end
         Q_LR: begin
            if (diff_ff[k_ff]) begin
               tcmd     = '{en: 1'b1, we: 1'b0};
               state_in = Q_LC;
            end else if (k_ff == LW'(LEVELS - 1)) begin
               state_in = Q_EQ;
            end else begin
               k_in = k_ff + LW'(1);
            end
         end
         Q_LC: begin
            a_in = tdat;
            if (k_ff == LW'(LEVELS - 1)) begin
               state_in = Q_EQ;
            end else begin
               k_in     = k_ff + LW'(1);
               state_in = Q_LR;
            end
         end
         Q_EQ: begin
            k_in = LW'(LEVELS - 1);
            if (a_ff == b_ff) begin
               r_in     = a_ff;
               state_in = Q_PR;
            end else begin
               state_in = Q_JA;
            end
         end
         Q_JA: begin
            tcmd     = '{en: 1'b1, we: 1'b0};
            state_in = Q_JB;
         end
         Q_JB: begin
            r_in     = tdat;
            tcmd     = '{en: 1'b1, we: 1'b0};
            taddr    = {k_ff, AW'(b_ff)};
            rd_node  = b_ff;
            state_in = Q_JC;
         end
         Q_JC: begin
            if (r_ff != tdat) begin
               a_in = r_ff;
               b_in = tdat;
            end
            if (k_ff == '0) begin
               state_in = Q_ZR;
            end else begin
               k_in     = k_ff - LW'(1);
               state_in = Q_JA;
            end
         end
         Q_ZR: begin
            tcmd     = '{en: 1'b1, we: 1'b0};
            taddr    = {LW'(0), AW'(a_ff)};
            state_in = Q_ZC;
         end
         Q_ZC: begin
            r_in     = tdat;
            state_in = Q_PR;
         end
         Q_PR: begin
            tcmd     = '{en: 1'b1, we: 1'b0};
            taddr    = {LW'(0), AW'(r_ff)};
            rd_node  = r_ff;
            state_in = Q_PC;
         end
         Q_PC: begin
            b_in     = tdat;
            ncmd     = '{en: 1'b1, we: 1'b0};
            naddr    = AW'(r_ff);
            rd_node  = r_ff;
            state_in = Q_CZ;
         end
         Q_CZ: begin
            sum_in   = sum_ff - ndat[15:0];
            ncmd     = '{en: 1'b1, we: 1'b0};
            naddr    = AW'(b_ff);
            rd_node  = b_ff;
            state_in = Q_CP;
         end
         Q_CP: begin
            sum_in   = sum_ff - ndat[15:0];
            state_in = Q_OUT;
         end
         Q_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {sum_ff, r_ff};
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      zf_in = (rd_node == '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      a_ff        <= a_in;
      b_ff        <= b_in;
      r_ff        <= r_in;
      k_ff        <= k_in;
      diff_ff     <= diff_in;
      da_ff       <= da_in;
      ca_ff       <= ca_in;
      sum_ff      <= sum_in;
      zf_ff       <= zf_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef ASSERT_OFF
   a_ready_after_sieve: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> sieve_ready)
      else $error("word taken before sieve sweep finished");

   a_sentinel_load_dropped: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser[0] == OP_LOAD && req_tdata[15:0] == 16'd0)
      |=> state_ff == S_IDLE)
      else $error("load of node 0 was not dropped");

   a_result_only_from_query: assert property (@(posedge clock) disable iff (reset)
      ($rose(rsp_tvalid)) |-> $past(state_ff) == Q_OUT)
      else $error("result raised outside of query completion");
`endif
endmodule

// ----- sv/tplca_ram.sv -----
// Single-port synchronous RAM with registered read data.
// Depends on tplca_pkg for the command struct.
`timescale 1ns / 1ps
module tplca_ram #(
   parameter int WIDTH  = 16,
   parameter int ADDR_W = 4
) (
   input  logic                 clock,
   input  tplca_pkg::mem_cmd_type cmd,
   input  logic [ADDR_W-1:0]    addr,
   input  logic [WIDTH-1:0]     wdata,
   output logic [WIDTH-1:0]     rdata
);
   import tplca_pkg::*;

   logic [WIDTH-1:0] mem [2**ADDR_W];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (cmd.en) begin
         if (cmd.we) begin
            mem[addr] <= wdata;
         end else begin
            rdata_ff <= mem[addr];
         end
      end
   end

   assign rdata = rdata_ff;
endmodule

// ----- sv/tplca_sieve.sv -----
// Prime flag memory, filled by a sieve sweep after reset.
// Depends on tplca_pkg for the sieve size constants.
`timescale 1ns / 1ps
module tplca_sieve (
   input  logic                         clock,
   input  logic                         reset,
   input  logic [tplca_pkg::NODE_W-1:0] rd_addr,
   output logic                         rd_flag,
   output logic                         ready
);
   import tplca_pkg::*;

   typedef enum logic [2:0] {S_FILL, S_SEL, S_CHK, S_MARK, S_DONE} state_type;

   state_type   state_ff, state_in;
   logic [15:0] i_ff, i_in;
   logic [8:0]  p_ff, p_in;
   logic [16:0] j_ff, j_in;
   logic        mem [SIEVE_SIZE];
   logic        flag_ff;
   logic        we;
   logic [15:0] waddr;
   logic        wbit;
   logic [15:0] raddr;
   logic [16:0] j_next;

   assign j_next = j_ff + 17'(p_ff);

   always_comb begin
      state_in = state_ff;
      i_in     = i_ff;
      p_in     = p_ff;
      j_in     = j_ff;
      we       = 1'b0;
      waddr    = i_ff;
      wbit     = 1'b0;
      raddr    = rd_addr;
      unique case (state_ff)
         S_FILL: begin
            we    = 1'b1;
            waddr = i_ff;
            wbit  = (i_ff >= 16'd2);
            i_in  = i_ff + 16'd1;
            if (i_ff == 16'hFFFF) begin
               state_in = S_SEL;
               p_in     = 9'd2;
            end
         end
         S_SEL: begin
            raddr    = 16'(p_ff);
            state_in = S_CHK;
         end
         S_CHK: begin
            if (flag_ff) begin
               j_in     = 17'(p_ff) << 1;
               state_in = S_MARK;
            end else if (p_ff == 9'(SIEVE_ROOT - 1)) begin
               state_in = S_DONE;
            end else begin
               p_in     = p_ff + 9'd1;
               state_in = S_SEL;
            end
         end
         S_MARK: begin
            we    = 1'b1;
            waddr = j_ff[15:0];
            j_in  = j_next;
            if (j_next >= 17'(SIEVE_SIZE)) begin
               if (p_ff == 9'(SIEVE_ROOT - 1)) begin
                  state_in = S_DONE;
               end else begin
                  p_in     = p_ff + 9'd1;
                  state_in = S_SEL;
               end
            end
         end
         S_DONE: begin
            raddr = rd_addr;
         end
         default: state_in = S_FILL;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_FILL;
         i_ff     <= '0;
         p_ff     <= 9'd2;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         p_ff     <= p_in;
      end
      j_ff <= j_in;
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wbit;
      end
      flag_ff <= mem[raddr];
   end

   assign rd_flag = flag_ff;
   assign ready   = (state_ff == S_DONE);
endmodule

// ----- verif/testbench.sv -----
// Testbench for tree_path_prime_count_lca_core: builds random trees, runs path queries.
// Depends on tplca_pkg and the core; checks each result word against an in-bench predictor.
`timescale 1ns / 1ps
module testbench;
   import tplca_pkg::*;

   localparam int LV = DEF_LEVELS;
   localparam int NN = DEF_MAX_NODES;

   typedef struct {
      logic      op;
      bit [15:0] node_a;
      bit [15:0] node_b;
      bit        drain;
   } tree_cmd_type;

   typedef struct {
      bit [15:0] ancestor;
      bit [15:0] prime_count;
   } path_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [0:0]  req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   tree_cmd_type    cmd_queue[$];
   path_result_type expected_paths[$];
   int              error_count;
   bit              req_taken;
   int              burst_left;
   int              gap_left;
   int              stall_mode;
   int              mode_left;

   bit [15:0] lift_table[LV][NN];
   bit [15:0] depth_of[NN];
   bit [15:0] primes_to_root[NN];
   bit        is_prime[NN];

   bit        stim_loaded[NN];
   bit [15:0] stim_nodes[$];

   tree_path_prime_count_lca_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what, input bit [15:0] got,
                                  input bit [15:0] want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic void apply_load(bit [15:0] child, bit [15:0] parent);
      if (child == 0) return;
      lift_table[0][child] = parent;
      depth_of[child] = depth_of[parent] + 16'd1;
      primes_to_root[child] = primes_to_root[parent] + 16'(is_prime[child]);
      for (int k = 1; k < LV; k++)
         lift_table[k][child] = lift_table[k-1][lift_table[k-1][child]];
   endfunction

   function automatic path_result_type predict_path(bit [15:0] a, bit [15:0] b);
      bit [15:0]       t;
      bit [15:0]       gap;
      bit [15:0]       z;
      path_result_type r;
      r.prime_count = primes_to_root[a] + primes_to_root[b];
      if (depth_of[a] < depth_of[b]) begin
         t = a; a = b; b = t;
      end
      gap = depth_of[a] - depth_of[b];
      for (int k = 0; k < LV; k++)
         if (gap[k]) a = lift_table[k][a];
      if (a == b) begin
         z = a;
      end else begin
         for (int k = LV - 1; k >= 0; k--)
            if (lift_table[k][a] != lift_table[k][b]) begin
               a = lift_table[k][a];
               b = lift_table[k][b];
            end
         z = lift_table[0][a];
      end
      r.ancestor = z;
      r.prime_count = r.prime_count - primes_to_root[z] - primes_to_root[lift_table[0][z]];
      return r;
   endfunction

   function automatic bit [15:0] pick_loaded();
      if ($urandom_range(0, 19) == 0) return 16'd0;
      return stim_nodes[$urandom_range(0, stim_nodes.size() - 1)];
   endfunction

   task automatic add_load(input bit [15:0] child, input bit [15:0] parent);
      cmd_queue.insert(cmd_queue.size(), '{OP_LOAD, child, parent, 1'b0});
      if (child != 0 && !stim_loaded[child]) begin
         stim_loaded[child] = 1'b1;
         stim_nodes.insert(stim_nodes.size(), child);
      end
   endtask

   task automatic add_query(input bit [15:0] a, input bit [15:0] b, input bit drain);
      cmd_queue.insert(cmd_queue.size(), '{OP_QUERY, a, b, drain});
   endtask

   // driver
   always @(negedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!(req_tvalid && !req_taken)) begin
         if (cmd_queue.size() != 0 && cmd_queue[0].drain && expected_paths.size() != 0) begin
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (cmd_queue.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata  <= {cmd_queue[0].node_b, cmd_queue[0].node_a};
            req_tuser  <= cmd_queue[0].op;
            void'(cmd_queue.pop_front());
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 30);
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
      req_taken = 1'b0;
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left = $urandom_range(20, 400);
      end else begin
         mode_left--;
      end
      case (stall_mode)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 9) == 0);
         end
      endcase
   end

   // monitor and predictor
   always @(posedge clock) begin
      path_result_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_paths.size() == 0) begin
               $display("unexpected result word at %0t", $realtime);
               error_count++;
            end else begin
               want = expected_paths.pop_front();
               if (rsp_tdata[15:0] != want.ancestor)
                  report_mismatch("ancestor", rsp_tdata[15:0], want.ancestor);
               if (rsp_tdata[31:16] != want.prime_count)
                  report_mismatch("prime_count", rsp_tdata[31:16], want.prime_count);
            end
         end
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            if (req_tuser[0] == OP_LOAD)
               apply_load(req_tdata[15:0], req_tdata[31:16]);
            else
               expected_paths.insert(expected_paths.size(),
                                     predict_path(req_tdata[15:0], req_tdata[31:16]));
         end
      end
   end

   initial begin
      #20_000_000;
      $display("testbench: FAIL");
      $finish;
   end

   initial begin
      bit [15:0] child;
      bit [15:0] parent;
      bit [15:0] chain_tip;
      int        pick;
      error_count = 0;
      burst_left = 0;
      gap_left = 0;
      stall_mode = 0;
      mode_left = 0;
      req_taken = 1'b0;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      rsp_tready = 1'b0;
      reset = 1'b1;
      for (int i = 0; i < NN; i++) is_prime[i] = (i >= 2);
      for (int i = 2; i < NN; i++)
         if (is_prime[i])
            for (int j = 2 * i; j < NN; j += i) is_prime[j] = 1'b0;

      add_load(16'd1, 16'd0);
      add_load(16'd65535, 16'd1);
      add_load(16'd2, 16'd1);
      add_load(16'd3, 16'd2);
      add_load(16'd32768, 16'd3);
      add_load(16'd21845, 16'd32768);
      add_load(16'd43690, 16'd65535);
      add_load(16'd0, 16'd3);
      add_query(16'd21845, 16'd43690, 1'b0);
      add_query(16'd1, 16'd1, 1'b0);
      add_query(16'd0, 16'd0, 1'b0);
      add_query(16'd0, 16'd65535, 1'b0);
      add_query(16'd32768, 16'd3, 1'b0);
      add_load(16'd40000, 16'd0);
      add_load(16'd40001, 16'd40000);
      add_query(16'd40001, 16'd21845, 1'b0);
      add_load(16'd2, 16'd43690);
      add_query(16'd32768, 16'd2, 1'b1);
      add_query(16'd3, 16'd43690, 1'b0);
      add_query(16'd65535, 16'd65535, 1'b0);

      chain_tip = 16'd21845;
      for (int n = 0; n < 1500; n++) begin
         pick = $urandom_range(0, 99);
         if (pick < 48) begin
            add_query(pick_loaded(), pick_loaded(), (n % 500) == 499);
         end else if (pick < 94) begin
            do child = 16'($urandom_range(1, 65535)); while (stim_loaded[child]);
            parent = ($urandom_range(0, 1) == 0) ? chain_tip : pick_loaded();
            if ($urandom_range(0, 49) == 0) parent = 16'd0;
            add_load(child, parent);
            chain_tip = child;
         end else begin
            child = ($urandom_range(0, 2) == 0) ? 16'd0 : pick_loaded();
            add_load(child, pick_loaded());
         end
      end

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      while (cmd_queue.size() != 0 || (req_tvalid && !req_taken)) @(posedge clock);
      while (expected_paths.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (error_count == 0)
         $display("testbench: PASS");
      else
         $display("testbench: FAIL");
      $finish;
   end
endmodule

// ----- sim.f -----
sv/tplca_pkg.sv
sv/tplca_ram.sv
sv/tplca_sieve.sv
sv/tree_path_prime_count_lca_core.sv
verif/testbench.sv
